@@ src/qcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcs_pkg
// types and fixed constants for the quadrature counter with speed estimate
// ----------------------------------------------------------------------------
package qcs_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_COUNT_LIMIT = 2'd0;
    localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
    localparam logic [1:0] REG_SPEED_SCALE = 2'd2;

    // register reset values
    localparam logic [14:0] COUNT_LIMIT_RST = 15'd32000;
    localparam logic [14:0] SPEED_LIMIT_RST = 15'd32000;
    localparam logic [15:0] SPEED_SCALE_RST = 16'd1000;

    // quadrature step, indexed by {previous b, previous a, new b, new a}
    localparam logic signed [1:0] STEP_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         channel;
        logic               pin_a;
        logic               pin_b;
        logic [15:0]        elapsed_ms;
        logic signed [15:0] load_value;
    } t_item;

    typedef struct packed {
        logic [2:0]         channel_out;
        logic signed [15:0] count_out;
        logic [14:0]        speed_out;
    } t_result;

    // one channel's state as held in the channel memory
    typedef struct packed {
        logic [1:0]         phase;
        logic signed [15:0] count;
        logic signed [15:0] latched;
        logic [14:0]        speed;
    } t_entry;

endpackage

@@ src/quadrature_counter_speed.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_counter_speed
// multi-channel quadrature decoder with saturating position count and a
// speed estimate from a serial divider, channel state in one memory
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                         payload
//   --------  ---------  --------------------------------  --------------
//   item      in         start & !busy                     i_item
//   result    out        o_done, one cycle, cannot stall   o_result
//   config    in         psel & penable & pwrite (APB)     paddr / pwdata
//
// steps: sample, load, unused and out-of-range items go from one transfer
//   to the next via the memory read at the transfer, a busy state to modify
//   and write back, then the result cycle
// a speed tick goes through a busy state for the multiply, the state of the
//   one-bit restoring divider, a state for clamp and write back, then
//   the result cycle
// reset: synchronous active-low i_rst_n; per-entry valid bits make every
//   channel read as zero right after reset, no clearing pass needed
// busy drops at the edge that raises the result strobe, so the strobe cycle
//   is the first idle cycle and the next item can transfer at its end
//
module quadrature_counter_speed
    import qcs_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // item port
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,

    // result port
    output logic        o_done,
    output t_result     o_result,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // memory address width, at least one bit
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int XW = AW + 3;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // configuration registers
    logic [14:0] r_count_limit;
    logic [14:0] r_speed_limit;
    logic [15:0] r_speed_scale;

    // channel memory and its valid bits
    t_entry                  r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;
    t_entry                  r_rd_data;
    logic                    r_rd_vld;

    // item in flight
    logic [1:0]    r_state;
    t_item         r_item;
    logic          r_in_range;
    logic [AW-1:0] r_addr;

    // divider
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;

    // result
    logic    r_done;
    t_result r_result;

    // combinational
    logic          accept;
    logic [XW-1:0] addr_ext;
    logic [AW-1:0] addr_in;
    logic          in_range;
    t_entry        cur;
    logic          n_mem_we;
    t_entry        n_entry;
    logic          n_done;
    t_result       n_result;
    logic [31:0]   n_product;
    logic [16:0]   trial;
    logic          trial_ge;

    // sample path
    logic [1:0]         levels;
    logic signed [1:0]  dir;
    logic signed [16:0] cnt17;
    logic signed [16:0] lim17;

    // tick path
    logic signed [16:0] diff17;
    logic [16:0]        mag17;
    logic [14:0]        speed_new;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign addr_ext = XW'(i_item.channel);
    assign addr_in  = addr_ext[AW-1:0];
    assign in_range = (int'(i_item.channel) < NUM_CHANNELS);

    // an entry not written since reset reads as zero
    assign cur = r_rd_vld ? r_rd_data : '0;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit <= COUNT_LIMIT_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
            r_speed_scale <= SPEED_SCALE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_COUNT_LIMIT: r_count_limit <= pwdata[14:0];
                REG_SPEED_LIMIT: r_speed_limit <= pwdata[14:0];
                REG_SPEED_SCALE: r_speed_scale <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COUNT_LIMIT: prdata = {17'd0, r_count_limit};
            REG_SPEED_LIMIT: prdata = {17'd0, r_speed_limit};
            REG_SPEED_SCALE: prdata = {16'd0, r_speed_scale};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // modify logic
    // ------------------------------------------------------------------

    // quadrature step against the saturation window
    assign levels = {r_item.pin_b, r_item.pin_a};
    assign dir    = STEP_TABLE[{cur.phase, levels}];
    assign cnt17  = 17'(cur.count);
    assign lim17  = signed'({2'b00, r_count_limit});

    // position change since the last tick, as a magnitude
    assign diff17 = 17'(cur.count) - 17'(cur.latched);
    assign mag17  = diff17[16] ? 17'(-diff17) : 17'(diff17);

    // product of the magnitude (at most 65535) and the scale
    assign n_product = mag17[15:0] * r_speed_scale;

    // one restoring division step, quotient bits shift in at the bottom
    assign trial    = {r_rem, r_quo[31]};
    assign trial_ge = (trial >= {1'b0, r_den});

    // clamp to the speed limit, a zero result lets the stored speed decay
    always_comb begin
        if (r_quo > {17'd0, r_speed_limit}) begin
            speed_new = r_speed_limit;
        end else begin
            speed_new = r_quo[14:0];
        end
        if (speed_new == 15'd0) begin
            speed_new = (cur.speed != 15'd0) ? cur.speed - 15'd1 : 15'd0;
        end
    end

    always_comb begin
        n_mem_we = 1'b0;
        n_entry  = cur;
        n_done   = 1'b0;

        if (r_state == S_EXEC) begin
            if (!r_in_range) begin
                n_done = 1'b1;
            end else begin
                unique case (r_item.operation)
                    OP_SAMPLE: begin
                        n_mem_we      = 1'b1;
                        n_done        = 1'b1;
                        n_entry.phase = levels;
                        if (dir < 0 && cnt17 > -lim17) begin
                            n_entry.count = cur.count - 16'sd1;
                        end else if (dir > 0 && cnt17 < lim17) begin
                            n_entry.count = cur.count + 16'sd1;
                        end
                    end
                    OP_LOAD: begin
                        n_mem_we        = 1'b1;
                        n_done          = 1'b1;
                        n_entry.count   = r_item.load_value;
                        n_entry.latched = r_item.load_value;
                    end
                    OP_TICK: ;
                    default: n_done = 1'b1;
                endcase
            end
        end else if (r_state == S_FIN) begin
            n_mem_we        = 1'b1;
            n_done          = 1'b1;
            n_entry.speed   = speed_new;
            n_entry.latched = cur.count;
        end

        n_result.channel_out = r_item.channel;
        n_result.count_out   = r_in_range ? n_entry.count : 16'sd0;
        n_result.speed_out   = r_in_range ? n_entry.speed : 15'd0;
    end

    // ------------------------------------------------------------------
    // channel memory, read at the item transfer, written at the end
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_mem[addr_in];
        end
        if (n_mem_we) begin
            r_mem[r_addr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_rd_vld <= in_range ? r_vld[addr_in] : 1'b0;
            end
            if (n_mem_we) begin
                r_vld[r_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= n_done;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // only an in-range tick needs the divider
                    if (r_in_range && r_item.operation == OP_TICK) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item, divider and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item     <= i_item;
            r_in_range <= in_range;
            r_addr     <= addr_in;
        end
        if (r_state == S_EXEC) begin
            r_quo <= n_product;
            r_rem <= '0;
            // zero elapsed time counts as one millisecond
            r_den <= (r_item.elapsed_ms == 16'd0) ? 16'd1 : r_item.elapsed_ms;
        end else if (r_state == S_DIV) begin
            r_quo <= {r_quo[30:0], trial_ge};
            r_rem <= trial_ge ? 16'(trial - {1'b0, r_den}) : trial[15:0];
        end
        if (n_done) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
